// ===== src/tfn_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tfn_pkg
// Shared widths for the triangle face normal pipeline.
// ============================================================================
package tfn_pkg;
    localparam int MAG_BITS  = 31;   // normalized magnitude width
    localparam int SUMSQ_BITS = 64;
    localparam int ROOT_BITS = 32;
endpackage

// ===== src/tfn_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tfn_if
// Valid/ready channel carrying a generic payload.
// ============================================================================
interface tfn_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/triangle_face_normal_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// triangle_face_normal_top
// Unit face normal of a triangle: edges, cross product, block
// normalization, sum of squares, integer square root, per-axis division.
// ============================================================================
//  channel  direction  payload
//  s_tri    in         v0..v2 xyz, COORD_BITS each, signed
//  m_nrm    out        normal xyz NORMAL_BITS signed, degenerate
//
//  One triangle per cycle while not stalled. The pipeline has 7 front stages, 32 square root
//  stages and NORMAL_BITS+31 divider stages, then an output register.
//  The whole pipeline advances together and holds while the output
//  register is full and not taken. Reset clears only valid bits.
// ============================================================================
module triangle_face_normal_top
    import tfn_pkg::*;
#(
    parameter int COORD_BITS  = 24,
    parameter int NORMAL_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tfn_if.sink   s_tri,
    tfn_if.source m_nrm
);
    localparam int CB   = COORD_BITS;
    localparam int EB   = CB + 1;
    localparam int PB   = 2 * EB;
    localparam int XB   = PB + 1;          // cross component width
    localparam int LB   = $clog2(XB + 1);  // bit length width
    localparam int FB   = NORMAL_BITS - 2;
    localparam int NB   = MAG_BITS + FB + 2;   // numerator width
    localparam int DB   = ROOT_BITS + 1;
    localparam int SQ_N = ROOT_BITS;

    logic w_en;
    logic r_ov;
    assign w_en = !r_ov || m_nrm.ready;
    assign s_tri.ready = w_en;

    // ---------- stage 1: edges
    logic signed [CB-1:0] w_v [9];
    for (genvar i = 0; i < 9; i++) begin : g_v
        assign w_v[i] = s_tri.data[i*CB +: CB];
    end
    logic signed [EB-1:0] r_e1 [3];
    logic signed [EB-1:0] r_e2 [3];
    logic r_v1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= s_tri.valid;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EB'(w_v[3+i]) - EB'(w_v[i]);
                r_e2[i] <= EB'(w_v[6+i]) - EB'(w_v[i]);
            end
        end
    end

    // ---------- stage 2: products
    logic signed [PB-1:0] r_p [6];
    logic r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_en) r_v2 <= r_v1;
        if (w_en) begin
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
        end
    end

    // ---------- stage 3: cross, sign, magnitude
    logic [XB-1:0] r_c [3];
    logic [2:0]    r_n3;
    logic r_v3;
    always_ff @(posedge i_clk) begin
        logic signed [XB-1:0] c;
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_en) r_v3 <= r_v2;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                c = XB'(r_p[2*i]) - XB'(r_p[2*i+1]);
                r_n3[i] <= c[XB-1];
                r_c[i]  <= c[XB-1] ? XB'(-c) : XB'(c);
            end
        end
    end

    // ---------- stage 4: bit length of OR (max bit length)
    logic [XB-1:0] r_c4 [3];
    logic [2:0]    r_n4;
    logic [LB-1:0] r_b;
    logic r_v4;
    always_ff @(posedge i_clk) begin
        logic [XB-1:0] o;
        logic [LB-1:0] b;
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_en) r_v4 <= r_v3;
        if (w_en) begin
            o = r_c[0] | r_c[1] | r_c[2];
            b = '0;
            for (int k = 0; k < XB; k++) begin
                if (o[k]) b = LB'(k + 1);
            end
            r_b  <= b;
            r_c4 <= r_c;
            r_n4 <= r_n3;
        end
    end

    // ---------- stage 5: block shift to 31 bits
    logic [MAG_BITS-1:0] r_m [3];
    logic [2:0] r_n5;
    logic r_dg5;
    logic r_v5;
    always_ff @(posedge i_clk) begin
        logic [XB+MAG_BITS-1:0] t;
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (w_en) r_v5 <= r_v4;
        if (w_en) begin
            r_dg5 <= (r_b == '0);
            r_n5  <= r_n4;
            for (int i = 0; i < 3; i++) begin
                t = {r_c4[i], {MAG_BITS{1'b0}}} >> r_b;
                r_m[i] <= t[MAG_BITS-1:0];
            end
        end
    end

    // ---------- stage 6: squares
    logic [2*MAG_BITS-1:0] r_sq [3];
    logic [MAG_BITS-1:0] r_m6 [3];
    logic [2:0] r_n6;
    logic r_dg6, r_v6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (w_en) r_v6 <= r_v5;
        if (w_en) begin
            for (int i = 0; i < 3; i++) r_sq[i] <= r_m[i] * r_m[i];
            r_m6 <= r_m; r_n6 <= r_n5; r_dg6 <= r_dg5;
        end
    end

    // ---------- stage 7: sum
    logic [SUMSQ_BITS-1:0] r_s;
    logic [MAG_BITS-1:0] r_m7 [3];
    logic [2:0] r_n7;
    logic r_dg7, r_v7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else if (w_en) r_v7 <= r_v6;
        if (w_en) begin
            r_s <= SUMSQ_BITS'(r_sq[0]) + SUMSQ_BITS'(r_sq[1]) + SUMSQ_BITS'(r_sq[2]);
            r_m7 <= r_m6; r_n7 <= r_n6; r_dg7 <= r_dg6;
        end
    end

    // ---------- square root: one result bit per stage
    logic [SUMSQ_BITS-1:0] r_sx [SQ_N+1];
    logic [ROOT_BITS-1:0]  r_sr [SQ_N+1];
    logic [SUMSQ_BITS+1:0] r_srm[SQ_N+1];
    logic [MAG_BITS-1:0]   r_sm [SQ_N+1][3];
    logic [2:0]            r_sn [SQ_N+1];
    logic                  r_sd [SQ_N+1];
    logic                  r_sv [SQ_N+1];
    always_comb begin
        r_sx[0] = r_s; r_sr[0] = '0; r_srm[0] = '0;
        r_sm[0] = r_m7; r_sn[0] = r_n7; r_sd[0] = r_dg7; r_sv[0] = r_v7;
    end
    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        logic [SUMSQ_BITS+1:0] n_rm, n_tr;
        always_comb begin
            n_rm = {r_srm[k][SUMSQ_BITS-1:0],
                    r_sx[k][SUMSQ_BITS-1 -: 2]};
            n_tr = n_rm - {{(SUMSQ_BITS-ROOT_BITS){1'b0}}, r_sr[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else if (w_en) r_sv[k+1] <= r_sv[k];
            if (w_en) begin
                r_sx[k+1] <= {r_sx[k][SUMSQ_BITS-3:0], 2'b00};
                r_sm[k+1] <= r_sm[k];
                r_sn[k+1] <= r_sn[k];
                r_sd[k+1] <= r_sd[k];
                if (!n_tr[SUMSQ_BITS+1]) begin
                    r_srm[k+1] <= n_tr;
                    r_sr[k+1]  <= {r_sr[k][ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_srm[k+1] <= n_rm;
                    r_sr[k+1]  <= {r_sr[k][ROOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // ---------- three dividers: (m<<(F+1) + L) / 2L
    localparam int TB = 4;
    logic [2:0]    w_dv;
    logic [NB-1:0] w_q [3];
    logic [TB-1:0] w_t [3];
    for (genvar i = 0; i < 3; i++) begin : g_dv
        logic [NB-1:0] n_num;
        assign n_num = (NB'(r_sm[SQ_N][i]) << (FB + 1)) + NB'(r_sr[SQ_N]);
        tfn_div #(.NUM_BITS(NB), .DEN_BITS(DB), .TAG_BITS(TB)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_sv[SQ_N]),
            .i_num   (n_num),
            .i_den   ({r_sr[SQ_N], 1'b0}),
            .i_tag   ({r_sv[SQ_N], r_sd[SQ_N], 1'b0, r_sn[SQ_N][i]}),
            .o_valid (w_dv[i]),
            .o_quo   (w_q[i]),
            .o_tag   (w_t[i])
        );
    end

    // ---------- output register
    logic [NORMAL_BITS-1:0] r_o [3];
    logic r_odg;
    always_ff @(posedge i_clk) begin
        logic [NORMAL_BITS-1:0] q;
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_dv[0];
        if (w_en) begin
            r_odg <= w_t[0][2];
            for (int i = 0; i < 3; i++) begin
                q = w_q[i][NORMAL_BITS-1:0];
                if (w_t[0][2]) r_o[i] <= '0;
                else r_o[i] <= w_t[i][0] ? NORMAL_BITS'(-q) : q;
            end
        end
    end

    assign m_nrm.valid = r_ov;
    assign m_nrm.data  = {r_odg, r_o[2], r_o[1], r_o[0]};

`ifndef SYNTHESIS
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv[0] == w_dv[1]) && (w_dv[1] == w_dv[2])) else $error("div lanes skew");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_nrm.ready) |=> (r_ov && $stable(m_nrm.data))) else $error("output lost");
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_odg) |-> (r_o[0] == '0 && r_o[1] == '0 && r_o[2] == '0))
        else $error("degenerate not zero");
`endif
endmodule

// ===== src/tfn_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tfn_div
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ============================================================================
module tfn_div
    import tfn_pkg::*;
#(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 33,
    parameter int TAG_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    input  logic [TAG_BITS-1:0] i_tag,
    output logic                o_valid,
    output logic [NUM_BITS-1:0] o_quo,
    output logic [TAG_BITS-1:0] o_tag
);
    localparam int R_BITS = DEN_BITS + 1;

    logic [NUM_BITS-1:0] r_q   [NUM_BITS+1];
    logic [R_BITS-1:0]   r_rem [NUM_BITS+1];
    logic [DEN_BITS-1:0] r_den [NUM_BITS+1];
    logic [TAG_BITS-1:0] r_tag [NUM_BITS+1];
    logic                r_v   [NUM_BITS+1];

    always_comb begin
        r_q[0]   = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
        r_v[0]   = i_valid;
    end

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_st
        logic [R_BITS-1:0] n_try;
        logic [R_BITS-1:0] n_sh;
        always_comb begin
            n_sh  = {r_rem[k][R_BITS-2:0], r_q[k][NUM_BITS-1]};
            n_try = n_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
                if (!n_try[R_BITS-1]) begin
                    r_rem[k+1] <= n_try;
                    r_q[k+1]   <= {r_q[k][NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_sh;
                    r_q[k+1]   <= {r_q[k][NUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[NUM_BITS];
    assign o_quo   = r_q[NUM_BITS];
    assign o_tag   = r_tag[NUM_BITS];
endmodule
